/* rtl/b64c_pkg.sv */
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, register codes and alphabet functions for the LSB-first
// Base64 codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

    localparam int DATA_W   = 8;
    localparam int LIMIT_W  = 16;
    localparam int MAX_RES  = 4;
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);
    localparam int RES_IDX_W = $clog2(MAX_RES);

    // Configuration register indexes.
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    // Mode codes.
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

    typedef struct packed {
        logic               mode;
        logic [LIMIT_W-1:0] limit;
        logic               clr;
    } t_cfg;

    // All results caused by one input beat.
    typedef struct packed {
        logic [MAX_RES-1:0][DATA_W-1:0] data;
        logic [RES_CNT_W-1:0]           cnt;
        logic                           last;
    } t_grp;

    // Map a 6-bit value to its alphabet character.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'h41;
        end else if (v < 6'd52) begin
            return w + 8'h47;
        end else if (v < 6'd62) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

    // Map a character to its 6-bit value; anything outside the alphabet is 0.
    function automatic logic [5:0] b64_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c inside {[8'h41:8'h5A]}) begin
            t = c - 8'h41;
        end else if (c inside {[8'h61:8'h7A]}) begin
            t = c - 8'h47;
        end else if (c inside {[8'h30:8'h39]}) begin
            t = c + 8'd4;
        end else if (c == 8'h2B) begin
            t = 8'd62;
        end else if (c == 8'h2F) begin
            t = 8'd63;
        end
        return t[5:0];
    endfunction

endpackage

/* rtl/b64c_step.sv */
// ----------------------------------------------------------------------------
// b64c_step
// Input register, bit buffer state and the single-pass encode/decode step
// that turns one registered beat into a group of up to four results.
// ----------------------------------------------------------------------------
module b64c_step
    import b64c_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [DATA_W-1:0] i_data_in,
    input  logic              i_last_in,
    output logic              o_in_stall,
    input  t_cfg              i_cfg,
    input  logic              i_grp_free,
    output logic              o_grp_load,
    output t_grp              o_grp
);

    logic              r_in_vld;
    logic [DATA_W-1:0] r_in_data;
    logic              r_in_last;
    logic [6:0]        r_store;
    logic [2:0]        r_cnt;
    logic [LIMIT_W-1:0] r_emit;

    logic [6:0]         n_store;
    logic [2:0]         n_cnt;
    logic [LIMIT_W-1:0] n_emit;

    logic consume;
    logic take;

    // Encode path
    logic [23:0] e_buf;
    logic [4:0]  e_tot;
    logic [1:0]  e_full;
    logic [4:0]  e_rem;
    logic [2:0]  e_n;
    logic [6:0]  e_store;

    // Decode path
    logic [14:0] d_buf;
    logic [3:0]  d_tot;
    logic        d_full;
    logic [3:0]  d_rem;
    logic        d_cand_a;
    logic        d_cand_b;
    logic        d_keep_a;
    logic        d_keep_b;
    logic [LIMIT_W:0] d_emit_inc;
    logic [2:0]  d_n;

    assign consume    = r_in_vld && i_grp_free;
    assign o_in_stall = r_in_vld && !i_grp_free;
    assign take       = i_in_valid && !o_in_stall;

    always_comb begin
        e_buf = {17'b0, r_store} | ({16'b0, r_in_data} << r_cnt);
        e_tot = {2'b00, r_cnt} + (r_in_last ? 5'd16 : 5'd8);
        if (e_tot >= 5'd18) begin
            e_full = 2'd3;
        end else if (e_tot >= 5'd12) begin
            e_full = 2'd2;
        end else begin
            e_full = 2'd1;
        end
        e_rem = e_tot - ({3'b000, e_full} * 5'd6);
        // A last beat flushes any partial group as one extra character.
        e_n = {1'b0, e_full} + {2'b00, (r_in_last && (e_rem != 5'd0))};
        e_store = (e_full == 2'd1) ? e_buf[12:6] : e_buf[18:12];
    end

    always_comb begin
        d_buf  = {8'b0, r_store} | ({9'b0, b64_value(r_in_data)} << r_cnt);
        d_tot  = {1'b0, r_cnt} + 4'd6;
        d_full = (d_tot >= 4'd8);
        d_rem  = d_full ? (d_tot - 4'd8) : d_tot;
        d_cand_a = d_full || (r_in_last && (d_rem != 4'd0));
        d_cand_b = d_full && r_in_last && (d_rem != 4'd0);
        d_emit_inc = {1'b0, r_emit} + {{LIMIT_W{1'b0}}, 1'b1};
        d_keep_a = d_cand_a && (r_emit < i_cfg.limit);
        d_keep_b = d_cand_b && d_keep_a && (d_emit_inc < {1'b0, i_cfg.limit});
        d_n = {2'b00, d_keep_a} + {2'b00, d_keep_b};
    end

    always_comb begin
        o_grp.last = r_in_last;
        if (i_cfg.mode == MODE_ENC) begin
            o_grp.cnt     = e_n;
            o_grp.data[0] = b64_char(e_buf[5:0]);
            o_grp.data[1] = b64_char(e_buf[11:6]);
            o_grp.data[2] = b64_char(e_buf[17:12]);
            o_grp.data[3] = b64_char(e_buf[23:18]);
            n_store = e_store;
            n_cnt   = e_rem[2:0];
            n_emit  = r_emit;
        end else begin
            o_grp.cnt     = d_n;
            o_grp.data[0] = d_buf[7:0];
            o_grp.data[1] = {1'b0, d_buf[14:8]};
            o_grp.data[2] = '0;
            o_grp.data[3] = '0;
            n_store = d_full ? d_buf[14:8] : d_buf[6:0];
            n_cnt   = d_rem[2:0];
            n_emit  = r_emit + {{(LIMIT_W-1){1'b0}}, d_keep_a};
        end
        if (r_in_last) begin
            n_store = '0;
            n_cnt   = '0;
            n_emit  = '0;
        end
    end

    assign o_grp_load = consume && (o_grp.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (take) begin
            r_in_vld <= 1'b1;
        end else if (consume) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_data <= i_data_in;
            r_in_last <= i_last_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.clr) begin
            r_store <= '0;
            r_cnt   <= '0;
            r_emit  <= '0;
        end else if (consume) begin
            r_store <= n_store;
            r_cnt   <= n_cnt;
            r_emit  <= n_emit;
        end
    end

endmodule

/* rtl/b64c_ser.sv */
// ----------------------------------------------------------------------------
// b64c_ser
// Result group register that hands out one result beat per cycle while
// the output is not stalled, and frees itself as its final beat is taken.
// ----------------------------------------------------------------------------
module b64c_ser
    import b64c_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_grp_load,
    input  t_grp              i_grp,
    output logic              o_grp_free,
    output logic              o_out_valid,
    output logic [DATA_W-1:0] o_data_out,
    output logic              o_last_out,
    input  logic              i_out_stall
);

    logic                 r_vld;
    t_grp                 r_grp;
    logic [RES_IDX_W-1:0] r_idx;

    logic at_end;
    logic take;
    logic done;

    assign at_end = ({1'b0, r_idx} == (r_grp.cnt - {{(RES_CNT_W-1){1'b0}}, 1'b1}));
    assign take   = r_vld && !i_out_stall;
    assign done   = take && at_end;
    assign o_grp_free = !r_vld || done;

    assign o_out_valid = r_vld;
    assign o_data_out  = r_grp.data[r_idx];
    assign o_last_out  = r_vld && r_grp.last && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else if (i_grp_load) begin
            r_vld <= 1'b1;
            r_idx <= '0;
        end else if (done) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + {{(RES_IDX_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grp_load) begin
            r_grp <= i_grp;
        end
    end

endmodule

/* rtl/base64_lsb_first_codec_unit.sv */
// ----------------------------------------------------------------------------
// base64_lsb_first_codec_unit
// Base64-alphabet codec, bits packed least significant first, no padding.
//
//   Channel  Direction  Handshake                 Beat
//   input    in         i_in_valid / o_in_stall   i_data_in, i_last_in
//   output   out        o_out_valid / i_out_stall o_data_out, o_last_out
//   config   in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// An input beat is registered, then converted into a group of zero to four
// results held in the output group register. Results leave one per cycle
// while the output is not stalled; a group holds one or two results
// mid-stream when encoding, up to four on a last beat.
// A new beat is taken every cycle while the group register can be reloaded.
// Reset is synchronous and clears all control state; there is no clearing pass.
// ----------------------------------------------------------------------------
module base64_lsb_first_codec_unit
    import b64c_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [DATA_W-1:0]  i_data_in,
    input  logic               i_last_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [DATA_W-1:0]  o_data_out,
    output logic               o_last_out,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    logic               r_mode;
    logic [LIMIT_W-1:0] r_limit;
    t_cfg               cfg;
    t_grp               grp;
    logic               grp_load;
    logic               grp_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ENC;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:  r_mode  <= i_cfg_data[0];
                REG_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A mode write starts a fresh message.
    assign cfg.mode  = r_mode;
    assign cfg.limit = r_limit;
    assign cfg.clr   = i_cfg_we && (i_cfg_idx == REG_MODE);

    b64c_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_data_in  (i_data_in),
        .i_last_in  (i_last_in),
        .o_in_stall (o_in_stall),
        .i_cfg      (cfg),
        .i_grp_free (grp_free),
        .o_grp_load (grp_load),
        .o_grp      (grp)
    );

    b64c_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_load  (grp_load),
        .i_grp       (grp),
        .o_grp_free  (grp_free),
        .o_out_valid (o_out_valid),
        .o_data_out  (o_data_out),
        .o_last_out  (o_last_out),
        .i_out_stall (i_out_stall)
    );

endmodule

/* rtl/b64c_chk.sv */
// ----------------------------------------------------------------------------
// b64c_chk
// Port-level checks for the codec, attached to the top level by bind.
// ----------------------------------------------------------------------------
module b64c_chk
    import b64c_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [DATA_W-1:0]  o_data_out,
    input logic               o_last_out
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_data_out) && $stable(o_last_out))
        else $error("result beat changed while stalled");

    // The input only backs up behind a pending result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // Reset leaves both channels empty.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("channel busy right after reset");

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_out |-> o_out_valid)
        else $error("end-of-message flag without a result beat");

endmodule

bind base64_lsb_first_codec_unit b64c_chk u_chk (.*);
